// File: hw/rtl/ms_adpcm_block_decoder_defines.svh
// assertion macros for the ms adpcm block decoder checker
// depends on nothing; included by files that carry concurrent assertions
`ifndef MS_ADPCM_BLOCK_DECODER_DEFINES_SVH
`define MS_ADPCM_BLOCK_DECODER_DEFINES_SVH

// clocked assertion, disabled while reset is asserted (active low)
`define MSA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also runs through reset
`define MSA_ASSERT_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/msadpcm_pkg.sv
// shared types, constants and tables of the ms adpcm block decoder
// depends on nothing; imported by all decoder modules and the checker
package msadpcm_pkg;

	// configuration register map
	localparam int NUM_PAIRS = 7;
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W    = 5;
	localparam logic [REG_IDX_W-1:0] REG_STEREO = 3'd7;

	localparam logic [NUM_PAIRS-1:0][31:0] COEF_RESET = {
		32'd4279762312, 32'd4281335756, 32'd240, 32'd4194496,
		32'd0, 32'd4278190592, 32'd256
	};

	// block header layout
	localparam logic [3:0] HDR_LEN_MONO   = 4'd7;
	localparam logic [3:0] HDR_LEN_STEREO = 4'd14;
	localparam logic [7:0] IDX_MAX        = 8'd6;

	// step limits
	localparam logic signed [23:0] STEP_MIN = 24'sd16;
	localparam logic signed [23:0] STEP_MAX = 24'sd8388607;

	// command opcodes from the front end to the back end
	localparam logic [2:0] OP_SET_INDEX = 3'd0;
	localparam logic [2:0] OP_SET_STEP  = 3'd1;
	localparam logic [2:0] OP_SET_NEWER = 3'd2;
	localparam logic [2:0] OP_SET_OLDER = 3'd3;
	localparam logic [2:0] OP_DATA      = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic        ch;
		logic [15:0] value;
		logic        seeds;
		logic        stereo;
		logic        bad;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] pcm_sample;
		logic               channel;
		logic               last_of_run;
		logic               bad_predictor;
	} sample_t;

	// step adaptation factor per nibble code
	function automatic logic [9:0] adapt_factor(input logic [3:0] nib);
		logic [9:0] f;
		case (nib)
			4'd4, 4'd12: f = 10'd307;
			4'd5, 4'd11: f = 10'd409;
			4'd6, 4'd10: f = 10'd512;
			4'd7, 4'd9:  f = 10'd614;
			4'd8:        f = 10'd768;
			default:     f = 10'd230;
		endcase
		return f;
	endfunction

endpackage

// File: hw/rtl/msadpcm_if.sv
// valid/ready channel interfaces for coded bytes and decoded samples
// depends on nothing; used by the decoder top level and its sub-blocks
interface msadpcm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       block_start;

	modport source (output valid, data_byte, block_start, input ready);
	modport sink (input valid, data_byte, block_start, output ready);
endinterface

interface msadpcm_out_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] pcm_sample;
	logic              channel;
	logic              last_of_run;
	logic              bad_predictor;

	modport source (output valid, pcm_sample, channel, last_of_run, bad_predictor,
		input ready);
	modport sink (input valid, pcm_sample, channel, last_of_run, bad_predictor,
		output ready);
endinterface

// File: hw/rtl/msadpcm_cmdq.sv
// small command queue between the header parser and the decode engine
// depends on msadpcm_pkg
module msadpcm_cmdq import msadpcm_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/msadpcm_front.sv
// front end: takes coded bytes, tracks the header position and turns each
// data byte and header field into a command for the decode engine; depends on msadpcm_pkg
module msadpcm_front import msadpcm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         stereo_mode,
	msadpcm_in_if.sink   coded,
	output logic         push,
	output cmd_t         push_cmd,
	input  logic         full
);

	logic [3:0] hc_q;
	logic       bad_q;
	logic [7:0] latch_q;

	logic       accept;
	logic [3:0] pos;
	logic [3:0] pos_next;
	logic [3:0] pm2;
	logic [3:0] hlen;
	logic       is_data;
	logic       is_index;
	logic       is_latch;
	logic       idx_bad;
	logic [2:0] idx_val;
	logic       flag_new;
	logic [2:0] op;
	logic       ch;

	assign coded.ready = !full;
	assign accept      = coded.valid && !full;

	// classify the byte against the header layout
	always_comb begin
		pos      = coded.block_start ? 4'd0 : hc_q;
		hlen     = stereo_mode ? HDR_LEN_STEREO : HDR_LEN_MONO;
		is_data  = (pos >= hlen);
		pos_next = pos + 4'd1;
		pm2      = pos - 4'd2;
		idx_bad  = (coded.data_byte > IDX_MAX);
		idx_val  = idx_bad ? 3'd0 : coded.data_byte[2:0];
		is_index = 1'b0;
		is_latch = 1'b0;
		op       = OP_DATA;
		ch       = 1'b0;
		if (!is_data) begin
			if (!stereo_mode) begin
				case (pos)
					4'd0: begin
						is_index = 1'b1;
						op       = OP_SET_INDEX;
					end
					4'd1, 4'd3, 4'd5: is_latch = 1'b1;
					4'd2: op = OP_SET_STEP;
					4'd4: op = OP_SET_NEWER;
					default: op = OP_SET_OLDER;
				endcase
			end else if (pos <= 4'd1) begin
				is_index = 1'b1;
				op       = OP_SET_INDEX;
				ch       = pos[0];
			end else if (!pos[0]) begin
				is_latch = 1'b1;
			end else begin
				ch = pm2[1];
				if (pos <= 4'd5) begin
					op = OP_SET_STEP;
				end else if (pos <= 4'd9) begin
					op = OP_SET_NEWER;
				end else begin
					op = OP_SET_OLDER;
				end
			end
		end
		flag_new = (coded.block_start ? 1'b0 : bad_q) | (is_index & idx_bad);
	end

	// command towards the queue; low header bytes only update the latch
	always_comb begin
		push            = accept && (is_data || !is_latch);
		push_cmd.op     = op;
		push_cmd.ch     = ch;
		push_cmd.seeds  = !is_data && (pos_next == hlen);
		push_cmd.stereo = stereo_mode;
		push_cmd.bad    = flag_new;
		if (is_data) begin
			push_cmd.value = {8'd0, coded.data_byte};
		end else if (is_index) begin
			push_cmd.value = {13'd0, idx_val};
		end else begin
			push_cmd.value = {coded.data_byte, latch_q};
		end
	end

	// header position, flag and low byte latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q    <= 4'd0;
			bad_q   <= 1'b0;
			latch_q <= 8'd0;
		end else if (accept) begin
			hc_q  <= is_data ? pos : pos_next;
			bad_q <= flag_new;
			if (is_latch) begin
				latch_q <= coded.data_byte;
			end
		end
	end

endmodule

// File: hw/rtl/msadpcm_back.sv
// back end: per-channel predictor state, nibble decode through S_MUL and S_ACC, and
// the sample output register; depends on msadpcm_pkg
module msadpcm_back import msadpcm_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [NUM_PAIRS-1:0][31:0]   coefs,
	input  cmd_t                         head,
	input  logic                         empty,
	output logic                         pop,
	msadpcm_out_if.source                pcm
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_ACC  = 2'd2;
	localparam logic [1:0] S_SEED = 2'd3;

	localparam logic signed [28:0] PRED_MAX = 29'sd32767;
	localparam logic signed [28:0] PRED_MIN = -29'sd32768;
	localparam logic signed [26:0] ST_MIN   = 27'sd16;
	localparam logic signed [26:0] ST_MAX   = 27'sd8388607;

	logic [1:0] state_q;
	cmd_t       cur_q;
	logic       nib_q;
	logic [1:0] seed_q;

	logic [2:0]         pidx_q  [2];
	logic signed [23:0] step_q  [2];
	logic signed [15:0] newer_q [2];
	logic signed [15:0] older_q [2];

	logic               out_valid_q;
	sample_t            out_q;

	logic signed [31:0] p1_s1;
	logic signed [31:0] p2_s1;
	logic signed [27:0] pe_s1;
	logic signed [34:0] pa_s1;

	logic               out_free;
	logic               acc_fire;
	logic               seed_fire;
	logic               set_en;
	logic               cur_ch;
	logic               rd_ch;
	logic               wr_ch;
	logic [3:0]         nibble;
	logic [2:0]         pair_idx;
	logic [31:0]        pair;
	logic signed [15:0] c1;
	logic signed [15:0] c2;
	logic signed [3:0]  err;
	logic signed [10:0] factor;
	logic signed [32:0] sum;
	logic signed [24:0] base;
	logic signed [28:0] pred_full;
	logic signed [15:0] pred_new;
	logic signed [26:0] st_full;
	logic signed [23:0] step_new;
	logic               seed_newer;
	logic               seed_last;
	logic signed [15:0] seed_val;
	logic signed [15:0] rd_newer;
	logic signed [15:0] rd_older;
	logic signed [23:0] rd_step;

	assign out_free  = !out_valid_q || pcm.ready;
	assign pop       = (state_q == S_IDLE) && !empty;
	assign set_en    = pop && (head.op != OP_DATA);
	assign acc_fire  = (state_q == S_ACC) && out_free;
	assign seed_fire = (state_q == S_SEED) && out_free;

	// channel selection and state read port
	always_comb begin
		cur_ch     = cur_q.stereo & nib_q;
		nibble     = nib_q ? cur_q.value[3:0] : cur_q.value[7:4];
		seed_newer = cur_q.stereo ? seed_q[1] : seed_q[0];
		seed_last  = cur_q.stereo ? (seed_q == 2'd3) : (seed_q == 2'd1);
		rd_ch      = (state_q == S_SEED) ? (cur_q.stereo & seed_q[0]) : cur_ch;
		wr_ch      = (state_q == S_IDLE) ? head.ch : cur_ch;
		rd_newer   = newer_q[rd_ch];
		rd_older   = older_q[rd_ch];
		rd_step    = step_q[rd_ch];
		pair_idx   = (pidx_q[rd_ch] > 3'd6) ? 3'd0 : pidx_q[rd_ch];
		pair       = coefs[pair_idx];
		c1         = pair[15:0];
		c2         = pair[31:16];
		err        = nibble;
		factor     = {1'b0, adapt_factor(nibble)};
		seed_val   = seed_newer ? rd_newer : rd_older;
	end

	// products of one nibble
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			p1_s1 <= rd_newer * c1;
			p2_s1 <= rd_older * c2;
			pe_s1 <= err * rd_step;
			pa_s1 <= rd_step * factor;
		end
	end

	// prediction, clamp and step adaptation
	always_comb begin
		sum       = {p1_s1[31], p1_s1} + {p2_s1[31], p2_s1};
		base      = sum[32:8];
		pred_full = {{4{base[24]}}, base} + {pe_s1[27], pe_s1};
		if (pred_full > PRED_MAX) begin
			pred_new = 16'sd32767;
		end else if (pred_full < PRED_MIN) begin
			pred_new = -16'sd32768;
		end else begin
			pred_new = pred_full[15:0];
		end
		st_full = pa_s1[34:8];
		if (st_full < ST_MIN) begin
			step_new = STEP_MIN;
		end else if (st_full > ST_MAX) begin
			step_new = STEP_MAX;
		end else begin
			step_new = st_full[23:0];
		end
	end

	// per-channel predictor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				pidx_q[i]  <= 3'd0;
				step_q[i]  <= STEP_MIN;
				newer_q[i] <= 16'sd0;
				older_q[i] <= 16'sd0;
			end
		end else if (set_en) begin
			case (head.op)
				OP_SET_INDEX: pidx_q[wr_ch]  <= head.value[2:0];
				OP_SET_STEP:  step_q[wr_ch]  <= {{8{head.value[15]}}, head.value};
				OP_SET_NEWER: newer_q[wr_ch] <= head.value;
				OP_SET_OLDER: older_q[wr_ch] <= head.value;
				default: ;
			endcase
		end else if (acc_fire) begin
			step_q[wr_ch]  <= step_new;
			older_q[wr_ch] <= newer_q[wr_ch];
			newer_q[wr_ch] <= pred_new;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nib_q       <= 1'b0;
			seed_q      <= 2'd0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			cur_q       <= '0;
		end else begin
			if (pcm.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						cur_q  <= head;
						nib_q  <= 1'b0;
						seed_q <= 2'd0;
						if (head.op == OP_DATA) begin
							state_q <= S_MUL;
						end else if (head.seeds) begin
							state_q <= S_SEED;
						end
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (acc_fire) begin
						out_valid_q         <= 1'b1;
						out_q.pcm_sample    <= pred_new;
						out_q.channel       <= cur_ch;
						out_q.last_of_run   <= nib_q;
						out_q.bad_predictor <= cur_q.bad;
						nib_q               <= 1'b1;
						state_q             <= nib_q ? S_IDLE : S_MUL;
					end
				end
				S_SEED: begin
					if (seed_fire) begin
						out_valid_q         <= 1'b1;
						out_q.pcm_sample    <= seed_val;
						out_q.channel       <= rd_ch;
						out_q.last_of_run   <= seed_last;
						out_q.bad_predictor <= cur_q.bad;
						seed_q              <= seed_q + 2'd1;
						if (seed_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pcm.valid         = out_valid_q;
	assign pcm.pcm_sample    = out_q.pcm_sample;
	assign pcm.channel       = out_q.channel;
	assign pcm.last_of_run   = out_q.last_of_run;
	assign pcm.bad_predictor = out_q.bad_predictor;

endmodule

// File: hw/rtl/ms_adpcm_block_decoder.sv
// decode: an accepted data byte is queued, then popped by the decode engine in S_IDLE;
// each nibble passes S_MUL (products registered) and S_ACC (sample into the output
// register once it is free, so a stalled output holds the engine); no new command is
// popped until both nibbles are done; the last header byte adds 2 (mono) or 4 (stereo) seeds
// reset: asynchronous active low; coefficients return to their defaults, mono mode,
// step 16, samples zero, queue and output empty; no clearing pass
module ms_adpcm_block_decoder import msadpcm_pkg::*; #(
	parameter int CMDQ_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	msadpcm_in_if.sink           coded,
	msadpcm_out_if.source        pcm,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [NUM_PAIRS-1:0][31:0] coef_q;
	logic                       stereo_q;
	logic [REG_IDX_W-1:0]       reg_idx;
	logic                       cfg_wr;

	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	cmd_t head;
	logic empty;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= COEF_RESET;
			stereo_q <= 1'b0;
		end else if (cfg_wr) begin
			if (reg_idx == REG_STEREO) begin
				stereo_q <= pwdata[0];
			end else begin
				coef_q[reg_idx] <= pwdata;
			end
		end
	end

	// register read back
	always_comb begin
		if (reg_idx == REG_STEREO) begin
			prdata = {31'd0, stereo_q};
		end else begin
			prdata = coef_q[reg_idx];
		end
	end

	msadpcm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.stereo_mode (stereo_q),
		.coded       (coded),
		.push        (push),
		.push_cmd    (push_cmd),
		.full        (full)
	);

	msadpcm_cmdq #(
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	msadpcm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.coefs  (coef_q),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.pcm    (pcm)
	);

endmodule

// File: hw/rtl/msadpcm_checker.sv
// port-level checks of the ms adpcm block decoder, bound to the top level
// depends on msadpcm_pkg and ms_adpcm_block_decoder_defines.svh
`include "ms_adpcm_block_decoder_defines.svh"

module msadpcm_checker import msadpcm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [15:0]        pcm_sample,
	input logic               channel,
	input logic               last_of_run,
	input logic               bad_predictor,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [ADDR_W-1:0]  paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready
);

	// nothing pending on the output right after reset
	`MSA_ASSERT_NORST(a_out_empty_after_reset, clk, $rose(arst_n) |-> !out_valid, "sample valid right after reset")

	// a stalled sample transaction holds its payload
	`MSA_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(pcm_sample) && $stable(channel) && $stable(last_of_run) && $stable(bad_predictor), "stalled sample changed")

	// a coefficient write reads back unchanged
	`MSA_ASSERT(a_coef_readback, clk, arst_n, (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] != REG_STEREO) ##1 (psel && !pwrite && paddr == $past(paddr)) |-> prdata == $past(pwdata), "coefficient read back differs from write")

endmodule

bind ms_adpcm_block_decoder msadpcm_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (pcm.valid),
	.out_ready     (pcm.ready),
	.pcm_sample    (pcm.pcm_sample),
	.channel       (pcm.channel),
	.last_of_run   (pcm.last_of_run),
	.bad_predictor (pcm.bad_predictor),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.pwdata        (pwdata),
	.prdata        (prdata),
	.pready        (pready)
);
